// ===== rtl/sdrm_pkg.sv =====
// Shared types, constants and fixed-point helpers of the SDF raymarch shader.
package sdrm_pkg;

    localparam logic signed [31:0] SAT_MAX    = 32'sh7fffffff;
    localparam logic signed [31:0] SAT_MIN    = 32'sh80000000;
    localparam logic signed [31:0] EPS_HIT    = 32'sd655;
    localparam logic signed [31:0] EPS_SHADOW = 32'sd66;
    localparam int                 DIV_BITS   = 48;

    localparam logic [2:0] CFG_LIGHT_X      = 3'd0;
    localparam logic [2:0] CFG_LIGHT_Y      = 3'd1;
    localparam logic [2:0] CFG_LIGHT_Z      = 3'd2;
    localparam logic [2:0] CFG_FOCAL_LENGTH = 3'd3;
    localparam logic [2:0] CFG_PIXEL_PITCH  = 3'd4;
    localparam logic [2:0] CFG_SPHERE_RAD   = 3'd5;
    localparam logic [2:0] CFG_SPHERE_DEPTH = 3'd6;
    localparam logic [2:0] CFG_GROUND       = 3'd7;

    localparam logic [1:0] IDX_X = 2'd0;
    localparam logic [1:0] IDX_Y = 2'd1;
    localparam logic [1:0] IDX_Z = 2'd2;

    typedef enum logic [4:0] {
        OP_NOP, OP_LOAD, OP_RAY, OP_MUL, OP_ACC, OP_SQRT, OP_MAG, OP_UZERO,
        OP_DIV, OP_UQ, OP_DIRSET, OP_PWB, OP_QP, OP_SCENE, OP_DSET, OP_TADV,
        OP_QOFF, OP_NWB, OP_NSET, OP_NDL, OP_POFF, OP_STINIT, OP_QS,
        OP_NDLZERO, OP_STADV, OP_SHADE, OP_MISS
    } t_op;

    typedef enum logic [2:0] {
        MS_SQU, MS_SQD, MS_PT, MS_NL, MS_NE, MS_LS
    } t_msel;

    typedef struct packed {
        t_op        op;
        t_msel      msel;
        logic [1:0] idx;
    } t_cmd;

    typedef struct packed {
        logic sqrt_busy;
        logic div_busy;
        logic mag_zero;
        logic hit;
        logic blocked;
        logic out_room;
    } t_stat;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } t_vec;

    typedef struct packed {
        logic [63:0] rad;
        logic [63:0] root;
        logic [63:0] mask;
    } t_sq;

    function automatic logic signed [31:0] sat_add(logic signed [31:0] a,
                                                   logic signed [31:0] b);
        logic [32:0] s;
        s = {a[31], a} + {b[31], b};
        if (s[32] != s[31]) begin
            return s[32] ? SAT_MIN : SAT_MAX;
        end
        return s[31:0];
    endfunction

    function automatic logic signed [31:0] sat_sub(logic signed [31:0] a,
                                                   logic signed [31:0] b);
        logic [32:0] s;
        s = {a[31], a} - {b[31], b};
        if (s[32] != s[31]) begin
            return s[32] ? SAT_MIN : SAT_MAX;
        end
        return s[31:0];
    endfunction

    // product >> 16 (floor), saturated
    function automatic logic signed [31:0] fsat(logic signed [63:0] p);
        if (p[63:47] == {17{p[63]}}) begin
            return p[47:16];
        end
        return p[63] ? SAT_MIN : SAT_MAX;
    endfunction

    function automatic logic signed [31:0] vget(t_vec v, logic [1:0] idx);
        logic signed [31:0] r;
        unique case (idx)
            IDX_X:   r = v.x;
            IDX_Y:   r = v.y;
            default: r = v.z;
        endcase
        return r;
    endfunction

    function automatic t_vec vset(t_vec v, logic [1:0] idx, logic signed [31:0] val);
        t_vec r;
        r = v;
        unique case (idx)
            IDX_X:   r.x = val;
            IDX_Y:   r.y = val;
            default: r.z = val;
        endcase
        return r;
    endfunction

    function automatic t_sq sq_step(t_sq s);
        t_sq         r;
        logic [63:0] trial;
        trial = s.root + s.mask;
        r = s;
        if (s.rad >= trial) begin
            r.rad  = s.rad - trial;
            r.root = (s.root >> 1) + s.mask;
        end else begin
            r.root = s.root >> 1;
        end
        r.mask = s.mask >> 2;
        return r;
    endfunction

endpackage

// ===== rtl/sdrm_sqrt.sv =====
// Iterative 64-bit integer square root, two result bits per cycle.
module sdrm_sqrt (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_rad,
    output logic        o_busy,
    output logic [31:0] o_root
);
    import sdrm_pkg::*;

    t_sq r_s;
    t_sq n_s;

    always_comb begin
        n_s = sq_step(sq_step(r_s));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s.mask <= '0;
        end else if (i_start) begin
            r_s.rad  <= i_rad;
            r_s.root <= '0;
            r_s.mask <= 64'h4000_0000_0000_0000;
        end else if (o_busy) begin
            r_s <= n_s;
        end
    end

    assign o_busy = (r_s.mask != '0);
    assign o_root = r_s.root[31:0];

endmodule

// ===== rtl/sdrm_div.sv =====
// Restoring divider: signed num * 65536 / positive divisor, truncated, saturated.
module sdrm_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [31:0] i_num,
    input  logic        [30:0] i_den,
    output logic               o_busy,
    output logic signed [31:0] o_quot
);
    import sdrm_pkg::*;

    localparam int CNT_W = $clog2(DIV_BITS + 1);

    logic [CNT_W-1:0]    r_cnt;
    logic [DIV_BITS-1:0] r_quo;
    logic [30:0]         r_rem;
    logic [30:0]         r_den;
    logic                r_neg;

    logic [31:0]         num_mag;
    logic [31:0]         trial;
    logic                ge;
    logic [31:0]         diff;
    logic                too_big;

    always_comb begin
        num_mag = i_num[31] ? (~i_num + 32'd1) : i_num;
        trial   = {r_rem, r_quo[DIV_BITS-1]};
        ge      = (trial >= {1'b0, r_den});
        diff    = trial - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CNT_W'(DIV_BITS);
            r_quo <= {num_mag, 16'h0000};
            r_rem <= '0;
            r_den <= i_den;
            r_neg <= i_num[31];
        end else if (o_busy) begin
            r_cnt <= r_cnt - 1'b1;
            r_rem <= ge ? diff[30:0] : trial[30:0];
            r_quo <= {r_quo[DIV_BITS-2:0], ge};
        end
    end

    always_comb begin
        if (r_neg) begin
            too_big = (|r_quo[DIV_BITS-1:32]) || (r_quo[31] && (|r_quo[30:0]));
            o_quot  = too_big ? SAT_MIN : (~r_quo[31:0] + 32'd1);
        end else begin
            too_big = |r_quo[DIV_BITS-1:31];
            o_quot  = too_big ? SAT_MAX : r_quo[31:0];
        end
    end

    assign o_busy = (r_cnt != '0);

endmodule

// ===== rtl/sdrm_dp.sv =====
// Datapath: config registers, vector registers, shared multiplier, sqrt and divider.
module sdrm_dp #(
    parameter int ROWS = 240,
    parameter int COLS = 400
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  sdrm_pkg::t_cmd       i_cmd,
    output sdrm_pkg::t_stat      o_stat,
    input  logic [7:0]           i_pixel_row,
    input  logic [8:0]           i_pixel_col,
    input  logic                 i_cfg_valid,
    input  logic [2:0]           i_cfg_index,
    input  logic [15:0]          i_cfg_data,
    input  logic                 i_stall,
    output logic                 o_valid,
    output logic [7:0]           o_shade,
    output logic                 o_surface_hit
);
    import sdrm_pkg::*;

    logic signed [15:0] r_light_x, r_light_y, r_light_z;
    logic [14:0]        r_focal;
    logic [15:0]        r_pitch;
    logic [14:0]        r_srad;
    logic signed [15:0] r_sdepth, r_ground;

    logic [7:0]         r_row;
    logic [8:0]         r_col;
    t_vec               r_u, r_dir, r_p, r_q, r_n;
    logic signed [31:0] r_t, r_d, r_sc, r_ndl, r_st, r_mag;
    logic signed [63:0] r_prod;
    logic [63:0]        r_acc;
    logic               r_ovalid;
    logic [7:0]         r_shade;
    logic               r_hit;

    t_vec               lvec, dvec;
    logic signed [31:0] sd16, gh16, r16, g_dist, s_dist, scene_d;
    logic signed [31:0] mul_a, mul_b;
    logic signed [63:0] mul_p;
    logic signed [11:0] dcol, drow;
    logic signed [28:0] ray_xp, ray_yp;
    logic [39:0]        ndl255;
    logic [7:0]         shade_v;
    logic               ndl_pos;

    logic               sq_busy, dv_busy;
    logic [31:0]        sq_root;
    logic signed [31:0] dv_quot;

    always_comb begin
        lvec.x = {{14{r_light_x[15]}}, r_light_x, 2'b00};
        lvec.y = {{14{r_light_y[15]}}, r_light_y, 2'b00};
        lvec.z = {{14{r_light_z[15]}}, r_light_z, 2'b00};
        sd16   = {{12{r_sdepth[15]}}, r_sdepth, 4'h0};
        gh16   = {{12{r_ground[15]}}, r_ground, 4'h0};
        r16    = {13'h0000, r_srad, 4'h0};
        dvec.x = sat_sub(32'sd0, r_q.x);
        dvec.y = sat_sub(32'sd0, r_q.y);
        dvec.z = sat_sub(sd16, r_q.z);
        g_dist = sat_sub(gh16, r_q.y);
        s_dist = sat_sub(r_mag, r16);
        scene_d = (g_dist < s_dist) ? g_dist : s_dist;

        dcol   = $signed({2'b00, r_col, 1'b0}) - 12'(COLS);
        drow   = $signed({3'b000, r_row, 1'b0}) - 12'(ROWS);
        ray_xp = dcol * $signed({1'b0, r_pitch});
        ray_yp = drow * $signed({1'b0, r_pitch});

        ndl_pos = !r_ndl[31] && (r_ndl != 32'sd0);
        ndl255  = {r_ndl, 8'h00} - {8'h00, r_ndl};
        shade_v = (|ndl255[39:24]) ? 8'hff : ndl255[23:16];
    end

    always_comb begin
        unique case (i_cmd.msel)
            MS_SQU: begin
                mul_a = vget(r_u, i_cmd.idx);
                mul_b = vget(r_u, i_cmd.idx);
            end
            MS_SQD: begin
                mul_a = vget(dvec, i_cmd.idx);
                mul_b = vget(dvec, i_cmd.idx);
            end
            MS_PT: begin
                mul_a = vget(r_dir, i_cmd.idx);
                mul_b = r_t;
            end
            MS_NL: begin
                mul_a = vget(r_n, i_cmd.idx);
                mul_b = vget(lvec, i_cmd.idx);
            end
            MS_NE: begin
                mul_a = vget(r_n, i_cmd.idx);
                mul_b = EPS_HIT;
            end
            MS_LS: begin
                mul_a = vget(lvec, i_cmd.idx);
                mul_b = r_st;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_p = mul_a * mul_b;
    end

    sdrm_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.op == OP_SQRT),
        .i_rad   (r_acc),
        .o_busy  (sq_busy),
        .o_root  (sq_root)
    );

    sdrm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.op == OP_DIV),
        .i_num   (vget(r_u, i_cmd.idx)),
        .i_den   (r_mag[30:0]),
        .o_busy  (dv_busy),
        .o_quot  (dv_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_light_x <= 16'sd11585;
            r_light_y <= -16'sd11585;
            r_light_z <= 16'sd0;
            r_focal   <= 15'd4096;
            r_pitch   <= 16'd655;
            r_srad    <= 15'd4096;
            r_sdepth  <= 16'sd10240;
            r_ground  <= 16'sd4096;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_LIGHT_X:      r_light_x <= i_cfg_data;
                CFG_LIGHT_Y:      r_light_y <= i_cfg_data;
                CFG_LIGHT_Z:      r_light_z <= i_cfg_data;
                CFG_FOCAL_LENGTH: r_focal   <= i_cfg_data[14:0];
                CFG_PIXEL_PITCH:  r_pitch   <= i_cfg_data;
                CFG_SPHERE_RAD:   r_srad    <= i_cfg_data[14:0];
                CFG_SPHERE_DEPTH: r_sdepth  <= i_cfg_data;
                CFG_GROUND:       r_ground  <= i_cfg_data;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            OP_LOAD: begin
                r_row <= i_pixel_row;
                r_col <= i_pixel_col;
            end
            OP_RAY: begin
                r_u.x <= 32'(ray_xp >>> 1);
                r_u.y <= 32'(ray_yp >>> 1);
                r_u.z <= {13'h0000, r_focal, 4'h0};
            end
            OP_MUL:     r_prod <= mul_p;
            OP_ACC:     r_acc  <= (i_cmd.idx == IDX_X) ? $unsigned(r_prod)
                                                       : r_acc + $unsigned(r_prod);
            OP_MAG:     r_mag  <= sq_root[31] ? SAT_MAX : $signed(sq_root);
            OP_UZERO:   r_u    <= '0;
            OP_UQ:      r_u    <= vset(r_u, i_cmd.idx, dv_quot);
            OP_DIRSET: begin
                r_dir <= r_u;
                r_t   <= '0;
            end
            OP_PWB:     r_p    <= vset(r_p, i_cmd.idx, fsat(r_prod));
            OP_QP:      r_q    <= r_p;
            OP_SCENE:   r_sc   <= scene_d;
            OP_DSET:    r_d    <= r_sc;
            OP_TADV:    r_t    <= sat_add(r_t, r_d);
            OP_QOFF:    r_q    <= vset(r_p, i_cmd.idx,
                                       sat_add(vget(r_p, i_cmd.idx), EPS_HIT));
            OP_NWB:     r_u    <= vset(r_u, i_cmd.idx, sat_sub(r_sc, r_d));
            OP_NSET:    r_n    <= r_u;
            OP_NDL:     r_ndl  <= (i_cmd.idx == IDX_X) ? fsat(r_prod)
                                                       : sat_add(r_ndl, fsat(r_prod));
            OP_POFF:    r_p    <= vset(r_p, i_cmd.idx,
                                       sat_add(vget(r_p, i_cmd.idx), fsat(r_prod)));
            OP_STINIT:  r_st   <= EPS_SHADOW;
            OP_QS:      r_q    <= vset(r_q, i_cmd.idx,
                                       sat_add(vget(r_p, i_cmd.idx), fsat(r_prod)));
            OP_NDLZERO: r_ndl  <= '0;
            OP_STADV:   r_st   <= sat_add(r_st, r_sc);
            OP_SHADE: begin
                r_shade <= ndl_pos ? shade_v : 8'h00;
                r_hit   <= 1'b1;
            end
            OP_MISS: begin
                r_shade <= 8'h00;
                r_hit   <= 1'b0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.op == OP_SHADE || i_cmd.op == OP_MISS) begin
            r_ovalid <= 1'b1;
        end else if (!i_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    always_comb begin
        o_stat.sqrt_busy = sq_busy;
        o_stat.div_busy  = dv_busy;
        o_stat.mag_zero  = (r_mag == 32'sd0);
        o_stat.hit       = (r_sc <= EPS_HIT);
        o_stat.blocked   = (r_sc < EPS_SHADOW);
        o_stat.out_room  = !r_ovalid || !i_stall;
    end

    assign o_valid       = r_ovalid;
    assign o_shade       = r_shade;
    assign o_surface_hit = r_hit;

    a_out_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == OP_SHADE || i_cmd.op == OP_MISS) |-> (!r_ovalid || !i_stall))
        else $error("result written over an untaken transaction");

    a_div_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == OP_DIV) |-> (r_mag > 32'sd0))
        else $error("divide started with zero magnitude");

    a_sqrt_go: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == OP_SQRT) |=> sq_busy)
        else $error("square root did not start");

endmodule

// ===== rtl/sdrm_ctrl.sv =====
// Controller FSM sequencing ray setup, march, normal, shading and shadow loop.
module sdrm_ctrl #(
    parameter int MARCH_STEPS  = 30,
    parameter int SHADOW_STEPS = 10
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    output sdrm_pkg::t_cmd  o_cmd,
    input  sdrm_pkg::t_stat i_stat
);
    import sdrm_pkg::*;

    localparam int MAX_STEPS = (MARCH_STEPS > SHADOW_STEPS) ? MARCH_STEPS : SHADOW_STEPS;
    localparam int CW        = $clog2(MAX_STEPS + 1);

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_RAY    = 5'd1;
    localparam logic [4:0] S_MMUL   = 5'd2;
    localparam logic [4:0] S_MACC   = 5'd3;
    localparam logic [4:0] S_MSQRT  = 5'd4;
    localparam logic [4:0] S_MWAIT  = 5'd5;
    localparam logic [4:0] S_UCHK   = 5'd6;
    localparam logic [4:0] S_UDIV   = 5'd7;
    localparam logic [4:0] S_UDWAIT = 5'd8;
    localparam logic [4:0] S_SCFIN  = 5'd9;
    localparam logic [4:0] S_DIR    = 5'd10;
    localparam logic [4:0] S_PM     = 5'd11;
    localparam logic [4:0] S_PW     = 5'd12;
    localparam logic [4:0] S_QP     = 5'd13;
    localparam logic [4:0] S_MCHK   = 5'd14;
    localparam logic [4:0] S_TADV   = 5'd15;
    localparam logic [4:0] S_NQ     = 5'd16;
    localparam logic [4:0] S_NWB    = 5'd17;
    localparam logic [4:0] S_NSET   = 5'd18;
    localparam logic [4:0] S_LM     = 5'd19;
    localparam logic [4:0] S_LA     = 5'd20;
    localparam logic [4:0] S_OM     = 5'd21;
    localparam logic [4:0] S_OA     = 5'd22;
    localparam logic [4:0] S_STI    = 5'd23;
    localparam logic [4:0] S_SM     = 5'd24;
    localparam logic [4:0] S_SA     = 5'd25;
    localparam logic [4:0] S_SCHK   = 5'd26;
    localparam logic [4:0] S_OUT    = 5'd27;

    logic [4:0]    r_state, n_state;
    logic [4:0]    r_sret, n_sret;
    logic [4:0]    r_uret, n_uret;
    t_msel         r_msrc, n_msrc;
    logic [1:0]    r_k, n_k;
    logic [1:0]    r_j, n_j;
    logic [CW-1:0] r_step, n_step;
    logic          r_hitf, n_hitf;

    always_comb begin
        n_state    = r_state;
        n_sret     = r_sret;
        n_uret     = r_uret;
        n_msrc     = r_msrc;
        n_k        = r_k;
        n_j        = r_j;
        n_step     = r_step;
        n_hitf     = r_hitf;
        o_cmd.op   = OP_NOP;
        o_cmd.msel = r_msrc;
        o_cmd.idx  = r_k;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_hitf   = 1'b0;
                    n_state  = S_RAY;
                end
            end
            S_RAY: begin
                o_cmd.op = OP_RAY;
                n_msrc   = MS_SQU;
                n_k      = IDX_X;
                n_uret   = S_DIR;
                n_state  = S_MMUL;
            end
            S_MMUL: begin
                o_cmd.op = OP_MUL;
                n_state  = S_MACC;
            end
            S_MACC: begin
                o_cmd.op = OP_ACC;
                if (r_k == IDX_Z) begin
                    n_state = S_MSQRT;
                end else begin
                    n_k     = r_k + 2'd1;
                    n_state = S_MMUL;
                end
            end
            S_MSQRT: begin
                o_cmd.op = OP_SQRT;
                n_state  = S_MWAIT;
            end
            S_MWAIT: begin
                if (!i_stat.sqrt_busy) begin
                    o_cmd.op = OP_MAG;
                    n_k      = IDX_X;
                    n_state  = (r_msrc == MS_SQU) ? S_UCHK : S_SCFIN;
                end
            end
            S_UCHK: begin
                if (i_stat.mag_zero) begin
                    o_cmd.op = OP_UZERO;
                    n_state  = r_uret;
                end else begin
                    n_state  = S_UDIV;
                end
            end
            S_UDIV: begin
                o_cmd.op = OP_DIV;
                n_state  = S_UDWAIT;
            end
            S_UDWAIT: begin
                if (!i_stat.div_busy) begin
                    o_cmd.op = OP_UQ;
                    if (r_k == IDX_Z) begin
                        n_state = r_uret;
                    end else begin
                        n_k     = r_k + 2'd1;
                        n_state = S_UDIV;
                    end
                end
            end
            S_SCFIN: begin
                o_cmd.op = OP_SCENE;
                n_state  = r_sret;
            end
            S_DIR: begin
                o_cmd.op = OP_DIRSET;
                n_step   = '0;
                n_k      = IDX_X;
                n_state  = S_PM;
            end
            S_PM: begin
                o_cmd.op   = OP_MUL;
                o_cmd.msel = MS_PT;
                n_state    = S_PW;
            end
            S_PW: begin
                o_cmd.op = OP_PWB;
                if (r_k == IDX_Z) begin
                    n_state = S_QP;
                end else begin
                    n_k     = r_k + 2'd1;
                    n_state = S_PM;
                end
            end
            S_QP: begin
                o_cmd.op = OP_QP;
                n_msrc   = MS_SQD;
                n_k      = IDX_X;
                n_sret   = S_MCHK;
                n_state  = S_MMUL;
            end
            S_MCHK: begin
                o_cmd.op = OP_DSET;
                if (i_stat.hit) begin
                    n_hitf  = 1'b1;
                    n_j     = IDX_X;
                    n_state = S_NQ;
                end else begin
                    n_state = S_TADV;
                end
            end
            S_TADV: begin
                o_cmd.op = OP_TADV;
                if (r_step == CW'(MARCH_STEPS - 1)) begin
                    n_state = S_OUT;
                end else begin
                    n_step  = r_step + 1'b1;
                    n_k     = IDX_X;
                    n_state = S_PM;
                end
            end
            S_NQ: begin
                o_cmd.op  = OP_QOFF;
                o_cmd.idx = r_j;
                n_msrc    = MS_SQD;
                n_k       = IDX_X;
                n_sret    = S_NWB;
                n_state   = S_MMUL;
            end
            S_NWB: begin
                o_cmd.op  = OP_NWB;
                o_cmd.idx = r_j;
                if (r_j == IDX_Z) begin
                    n_msrc  = MS_SQU;
                    n_k     = IDX_X;
                    n_uret  = S_NSET;
                    n_state = S_MMUL;
                end else begin
                    n_j     = r_j + 2'd1;
                    n_state = S_NQ;
                end
            end
            S_NSET: begin
                o_cmd.op = OP_NSET;
                n_k      = IDX_X;
                n_state  = S_LM;
            end
            S_LM: begin
                o_cmd.op   = OP_MUL;
                o_cmd.msel = MS_NL;
                n_state    = S_LA;
            end
            S_LA: begin
                o_cmd.op = OP_NDL;
                if (r_k == IDX_Z) begin
                    n_k     = IDX_X;
                    n_state = S_OM;
                end else begin
                    n_k     = r_k + 2'd1;
                    n_state = S_LM;
                end
            end
            S_OM: begin
                o_cmd.op   = OP_MUL;
                o_cmd.msel = MS_NE;
                n_state    = S_OA;
            end
            S_OA: begin
                o_cmd.op = OP_POFF;
                if (r_k == IDX_Z) begin
                    n_state = S_STI;
                end else begin
                    n_k     = r_k + 2'd1;
                    n_state = S_OM;
                end
            end
            S_STI: begin
                o_cmd.op = OP_STINIT;
                n_step   = '0;
                n_k      = IDX_X;
                n_state  = S_SM;
            end
            S_SM: begin
                o_cmd.op   = OP_MUL;
                o_cmd.msel = MS_LS;
                n_state    = S_SA;
            end
            S_SA: begin
                o_cmd.op = OP_QS;
                if (r_k == IDX_Z) begin
                    n_msrc  = MS_SQD;
                    n_k     = IDX_X;
                    n_sret  = S_SCHK;
                    n_state = S_MMUL;
                end else begin
                    n_k     = r_k + 2'd1;
                    n_state = S_SM;
                end
            end
            S_SCHK: begin
                if (i_stat.blocked) begin
                    o_cmd.op = OP_NDLZERO;
                    n_state  = S_OUT;
                end else begin
                    o_cmd.op = OP_STADV;
                    if (r_step == CW'(SHADOW_STEPS - 1)) begin
                        n_state = S_OUT;
                    end else begin
                        n_step  = r_step + 1'b1;
                        n_k     = IDX_X;
                        n_state = S_SM;
                    end
                end
            end
            S_OUT: begin
                if (i_stat.out_room) begin
                    o_cmd.op = r_hitf ? OP_SHADE : OP_MISS;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_hitf  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_hitf  <= n_hitf;
        end
        r_sret <= n_sret;
        r_uret <= n_uret;
        r_msrc <= n_msrc;
        r_k    <= n_k;
        r_j    <= n_j;
        r_step <= n_step;
    end

    assign o_stall = (r_state != S_IDLE);

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("transaction accepted but controller stayed idle");

    a_out_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && i_stat.out_room) |=> !o_stall)
        else $error("controller did not return to idle after result");

endmodule

// ===== rtl/sdf_raymarch_pixel_shader_unit.sv =====
// Top level of the SDF sphere-tracing pixel shader.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+-------------------------------
//  pixel   | in        | i_valid / o_stall       | i_pixel_row, i_pixel_col
//  result  | out       | o_valid / i_stall       | o_shade, o_surface_hit
//  config  | in        | i_cfg_valid/o_cfg_ready | i_cfg_index, i_cfg_data
//
// One pixel at a time. A scene evaluation is set by the iterative square root;
// each normalization is set by three divides. A pixel's cost grows with each march
// step; a hit adds the normal, the shading and a cost for each shadow step.
// Reset is synchronous, active low; config registers return to their defaults.
// The result register frees the pixel side: a stalled transaction only holds
// the next pixel at its final write.
module sdf_raymarch_pixel_shader_unit #(
    parameter int ROWS         = 240,
    parameter int COLS         = 400,
    parameter int MARCH_STEPS  = 30,
    parameter int SHADOW_STEPS = 10
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_pixel_row,
    input  logic [8:0]  i_pixel_col,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_shade,
    output logic        o_surface_hit,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    import sdrm_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    sdrm_ctrl #(
        .MARCH_STEPS  (MARCH_STEPS),
        .SHADOW_STEPS (SHADOW_STEPS)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_cmd   (cmd),
        .i_stat  (stat)
    );

    sdrm_dp #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_pixel_row   (i_pixel_row),
        .i_pixel_col   (i_pixel_col),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_stall       (i_stall),
        .o_valid       (o_valid),
        .o_shade       (o_shade),
        .o_surface_hit (o_surface_hit)
    );

    assign o_cfg_ready = 1'b1;

endmodule
